>>> src/cosine_similarity_engine_unit_macros.svh
// Assertion macros used by the cosine similarity engine back end.
`ifndef COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, reset masked.
`define CSIM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csim assertion failed");

// Next-cycle implication, reset masked.
`define CSIM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csim assertion failed");

`endif

>>> src/csim_pkg.sv
`default_nettype none
package csim_pkg;

    localparam int ElemW = 16;
    localparam int AccW  = 48;
    localparam int WideW = 128;
    localparam int CntW  = 6;
    localparam int QW    = 16;

    typedef struct packed {
        logic signed [15:0] a_elem;
        logic signed [15:0] b_elem;
        logic               last_elem;
    } t_csim_in;

    typedef struct packed {
        logic signed [15:0] cosine;
        logic               undefined;
    } t_csim_out;

    typedef struct packed {
        logic signed [AccW-1:0] dot;
        logic signed [AccW-1:0] sq_a;
        logic signed [AccW-1:0] sq_b;
    } t_csim_sums;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CAP,
        ST_TRYA,
        ST_TRYB,
        ST_DONE
    } t_csim_state;

    localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

    function automatic logic signed [AccW-1:0] sat_add(
        input logic signed [AccW-1:0]    acc,
        input logic signed [2*ElemW-1:0] p
    );
        logic signed [AccW:0] s;
        s = {acc[AccW-1], acc} + {{(AccW+1-2*ElemW){p[2*ElemW-1]}}, p};
        if (s[AccW] != s[AccW-1]) begin
            sat_add = s[AccW] ? AccMin : AccMax;
        end else begin
            sat_add = s[AccW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> src/cosine_similarity_engine_unit.sv
// Cosine similarity engine: one element pair per cycle into the accumulators,
// unless the queue is full. The result follows the last item after a queue pop, a
// 48-step shift-add multiply, a clamp check, a 15-bit search (states TRYA, TRYB per
// bit) and an output load; the search is skipped when |cos| is 1.0, and the multiply
// and clamp check too when undefined. With two vectors queued, push stalls (full).
// Reset (i_rst_n low, synchronous) clears accumulators, queue and result valid flag.
`default_nettype none
module cosine_similarity_engine_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  csim_pkg::t_csim_in      i_data,
    output logic                    empty,
    input  wire logic               pop,
    output csim_pkg::t_csim_out     o_data
);
    import csim_pkg::*;

    // front: accumulate; hands completed sums to the queue on the last item
    logic       accept, f_push, q_pop, q_empty;
    t_csim_sums f_sums, q_sums;

    assign accept = push && !full;

    csim_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (f_push),
        .o_sums   (f_sums)
    );

    // two-entry queue decouples streaming from the slow ratio sequencer
    csim_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_sums  (f_sums),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_sums  (q_sums)
    );

    // back: largest q with q^2*sa*sb <= dot^2*2^30, signed and clamped
    csim_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_sums    (q_sums),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (o_data)
    );
endmodule
`default_nettype wire

>>> src/csim_front.sv
`default_nettype none
module csim_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  csim_pkg::t_csim_in      i_data,
    output logic                    o_push,
    output csim_pkg::t_csim_sums    o_sums
);
    import csim_pkg::*;

    t_csim_sums r_acc, n_acc;
    t_csim_sums sums;
    logic signed [2*ElemW-1:0] p_ab, p_aa, p_bb;

    always_comb begin
        p_ab = i_data.a_elem * i_data.b_elem;
        p_aa = i_data.a_elem * i_data.a_elem;
        p_bb = i_data.b_elem * i_data.b_elem;
        sums.dot  = sat_add(r_acc.dot,  p_ab);
        sums.sq_a = sat_add(r_acc.sq_a, p_aa);
        sums.sq_b = sat_add(r_acc.sq_b, p_bb);
        n_acc = r_acc;
        if (i_accept) begin
            n_acc = i_data.last_elem ? '0 : sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_push = i_accept && i_data.last_elem;
    assign o_sums = sums;
endmodule
`default_nettype wire

>>> src/csim_queue.sv
`default_nettype none
module csim_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  csim_pkg::t_csim_sums    i_sums,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output csim_pkg::t_csim_sums    o_sums
);
    import csim_pkg::*;

    t_csim_sums r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_sums  = r_mem[r_rd];
endmodule
`default_nettype wire

>>> src/csim_back.sv
`default_nettype none
`include "cosine_similarity_engine_unit_macros.svh"
module csim_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  csim_pkg::t_csim_sums    i_sums,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output csim_pkg::t_csim_out     o_data
);
    import csim_pkg::*;

    t_csim_state r_state, n_state;
    logic [WideW-1:0] r_mc_p, r_mc_d, r_acc_p, r_acc_d, r_s, r_qp, r_t;
    logic [AccW-1:0]  r_ml_p, r_ml_d;
    logic [CntW-1:0]  r_cnt;
    logic [3:0]       r_k;
    logic [QW-1:0]    r_q;
    logic             r_neg, r_undef;
    logic             r_out_valid;
    t_csim_out        r_out;

    logic [WideW-1:0] rhs, cand, cap_lhs;
    logic [AccW-1:0]  dot_mag;
    logic             out_free;
    logic signed [QW-1:0] res;

    // unsigned magnitude; the most negative sum gives 2^47
    assign dot_mag  = i_sums.dot[AccW-1] ? -i_sums.dot : i_sums.dot;
    assign rhs      = r_acc_d << 30;
    assign cand     = r_s + r_t;
    assign cap_lhs  = r_acc_p << 30;
    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        if (r_undef) begin
            res = '0;
        end else if (r_neg) begin
            res = -r_q;
        end else begin
            res = r_q[QW-1] ? 16'sh7FFF : r_q;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  if (r_undef || r_cnt == CntW'(AccW - 1)) n_state = r_undef ? ST_DONE : ST_CAP;
            ST_CAP:  n_state = (cap_lhs <= rhs) ? ST_DONE : ST_TRYA;
            ST_TRYA: n_state = ST_TRYB;
            ST_TRYB: n_state = (r_k == 4'd0) ? ST_DONE : ST_TRYA;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_neg   <= i_sums.dot[AccW-1];
                r_undef <= (i_sums.sq_a == '0) || (i_sums.sq_b == '0);
                r_mc_p  <= WideW'(i_sums.sq_a);
                r_ml_p  <= i_sums.sq_b;
                r_mc_d  <= WideW'(dot_mag);
                r_ml_d  <= dot_mag;
                r_acc_p <= '0;
                r_acc_d <= '0;
                r_cnt   <= '0;
                r_q     <= '0;
            end
            ST_MUL: begin
                if (r_ml_p[0]) r_acc_p <= r_acc_p + r_mc_p;
                if (r_ml_d[0]) r_acc_d <= r_acc_d + r_mc_d;
                r_mc_p <= r_mc_p << 1;
                r_mc_d <= r_mc_d << 1;
                r_ml_p <= r_ml_p >> 1;
                r_ml_d <= r_ml_d >> 1;
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_CAP: begin
                r_q  <= (cap_lhs <= rhs) ? 16'h8000 : 16'h0000;
                r_s  <= '0;
                r_qp <= '0;
                r_k  <= 4'd14;
            end
            ST_TRYA: begin
                r_t <= (r_qp << (r_k + 4'd1)) + (r_acc_p << {r_k, 1'b0});
            end
            ST_TRYB: begin
                if (cand <= rhs) begin
                    r_s      <= cand;
                    r_qp     <= r_qp + (r_acc_p << r_k);
                    r_q[r_k] <= 1'b1;
                end
                if (r_k != 4'd0) r_k <= r_k - 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.cosine    <= res;
            r_out.undefined <= r_undef;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

    `CSIM_ASSERT_IMP(a_undef_zero, r_out_valid && r_out.undefined, r_out.cosine == 16'sd0)
    `CSIM_ASSERT_NXT(a_mul_exit, r_state == ST_MUL && !r_undef,
        r_state == ST_MUL || r_state == ST_CAP)
    `CSIM_ASSERT_IMP(a_try_bit_free, r_state == ST_TRYB, r_q[r_k] == 1'b0)
endmodule
`default_nettype wire
